// File: hdl/frame_store_rect_and_glyph_draw_core_macros.svh
// Assertion macros shared by the drawing core.
// Each macro takes a label, the clock, the reset and the checked terms.
`ifndef FRAME_STORE_RECT_AND_GLYPH_DRAW_CORE_MACROS_SVH
`define FRAME_STORE_RECT_AND_GLYPH_DRAW_CORE_MACROS_SVH

// Same-cycle implication.
`define FSD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never be true.
`define FSD_ASSERT_NEVER(label, clk, rst, bad, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(bad)) \
    else $error(msg);

`endif

// File: hdl/fsd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the frame store drawing core.
// No dependencies; all other files but the RAM and macros import it.
package fsd_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 256;
  localparam int GLYPH_WIDTH = 12;

  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);

  localparam int PIX_W  = 16;
  localparam int REQ_W  = 3;
  localparam int POS_W  = 11;
  localparam int RECT_W = 10;

  localparam int FW_REG_W = 10;
  localparam int FH_REG_W = 9;
  localparam int FRAME_WIDTH_RESET  = 320;
  localparam int FRAME_HEIGHT_RESET = 240;

  localparam int WU_W = $clog2(MAX_WIDTH + 1);
  localparam int HU_W = $clog2(MAX_HEIGHT + 1);
  localparam int X_W  = $clog2(MAX_WIDTH);
  localparam int Y_W  = $clog2(MAX_HEIGHT);
  localparam int GK_W = $clog2(GLYPH_WIDTH);

  localparam int WH_W    = (WU_W > HU_W) ? WU_W : HU_W;
  localparam int CLIP_W  = ((WH_W > POS_W) ? WH_W : POS_W) + 2;
  localparam int PROD_W  = POS_W + WU_W + 1;
  localparam int IDX_W   = PROD_W + 1;
  localparam int X_OP_W  = POS_W + 1;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = REG_IDX_W'(1);

  localparam logic [REQ_W-1:0] REQ_CLEAR = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_FILL  = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_GLYPH = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_SET   = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_READ  = REQ_W'(4);

  // Frame geometry in use, after saturation of the registers.
  typedef struct packed {
    logic [WU_W-1:0]   width;
    logic [HU_W-1:0]   height;
    logic [ADDR_W-1:0] last;
  } fsd_geom_t;

  // One access to the frame memory: a write port and a read port.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } fsd_ram_cmd_t;

endpackage

// File: hdl/fsd_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for drawing requests and results.
// Depends on fsd_pkg for field widths.
interface fsd_req_if import fsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [RECT_W-1:0]        rect_width;
  logic [RECT_W-1:0]        rect_height;
  logic [PIX_W-1:0]         color;
  logic [GLYPH_WIDTH-1:0]   row_bits;

  modport source (output valid, req_type, pos_x, pos_y, rect_width, rect_height, color,
                  row_bits, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, rect_width, rect_height, color,
                row_bits, output ready);
endinterface

interface fsd_rsp_if import fsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] read_color;
  logic             empty_rect;
  logic             index_clamped;

  modport source (output valid, read_color, empty_rect, index_clamped, input ready);
  modport sink (input valid, read_color, empty_rect, index_clamped, output ready);
endinterface

// File: hdl/fsd_frame_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fsd_frame_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/fsd_cfg_regs.sv
`timescale 1ns / 1ps
// APB register file holding frame width and height, and the derived geometry.
// Depends on fsd_pkg.
module fsd_cfg_regs import fsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output fsd_geom_t             geom
);

  logic [FW_REG_W-1:0]  frame_width;
  logic [FH_REG_W-1:0]  frame_height;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [WU_W-1:0]      width_sat;
  logic [HU_W-1:0]      height_sat;
  logic [WU_W+HU_W-1:0] area;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_REG_W'(FRAME_WIDTH_RESET);
      frame_height <= FH_REG_W'(FRAME_HEIGHT_RESET);
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // Out-of-range register values are saturated into the legal frame size.
  always_comb begin
    if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      width_sat = WU_W'(MAX_WIDTH);
    end else if (frame_width == '0) begin
      width_sat = WU_W'(1);
    end else begin
      width_sat = WU_W'(frame_width);
    end
    if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      height_sat = HU_W'(MAX_HEIGHT);
    end else if (frame_height == '0) begin
      height_sat = HU_W'(1);
    end else begin
      height_sat = HU_W'(frame_height);
    end
  end

  assign area = width_sat * height_sat;

  always_ff @(posedge clk) begin
    geom.width  <= width_sat;
    geom.height <= height_sat;
    geom.last   <= ADDR_W'(area - 1);
  end

endmodule

// File: hdl/fsd_draw_seq.sv
`timescale 1ns / 1ps
// Command sequencer: clipping, index arithmetic and the pixel walk that
// drives the frame memory, plus the result register. Depends on fsd_pkg.
module fsd_draw_seq import fsd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  fsd_req_if.sink          req,
  fsd_rsp_if.source        rsp,
  input  fsd_geom_t        geom,
  output fsd_ram_cmd_t     ram_cmd,
  input  logic [PIX_W-1:0] ram_rdata
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CALC   = 7'b0000010,
    ST_CLEAR  = 7'b0000100,
    ST_FILL   = 7'b0001000,
    ST_PIXEL  = 7'b0010000,
    ST_RDWAIT = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [REQ_W-1:0]        cmd_type;
  logic signed [POS_W-1:0] cmd_x;
  logic signed [POS_W-1:0] cmd_y;
  logic [RECT_W-1:0]       cmd_w;
  logic [RECT_W-1:0]       cmd_h;
  logic [PIX_W-1:0]        cmd_color;
  logic [GLYPH_WIDTH-1:0]  glyph_bits;
  logic [GK_W-1:0]         glyph_cnt;

  logic signed [PROD_W-1:0] prod;
  logic [X_W-1:0]           x_lo, x_last, x_cnt;
  logic [Y_W-1:0]           y_last, y_cnt;
  logic [ADDR_W-1:0]        row_base;
  logic [ADDR_W-1:0]        clr_addr;

  logic [PIX_W-1:0] res_color;
  logic             res_empty;
  logic             res_clamped;

  logic signed [CLIP_W-1:0] x0, y0, x_end, y_end, lim_x, lim_y, sx, sy, ex, ey;
  logic                     fill_empty;
  logic signed [POS_W-1:0]  y_op;
  logic signed [PROD_W-1:0] mul_out;

  logic signed [X_OP_W-1:0] x_op;
  logic signed [IDX_W-1:0]  lin_idx;
  logic signed [IDX_W-1:0]  last_s;
  logic [ADDR_W-1:0]        pix_addr;
  logic                     pix_clamp;
  logic                     pix_hit;
  logic                     glyph_end;
  logic                     rsp_load;

  assign req.ready = (state == ST_IDLE);
  assign rsp_load  = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  // Rectangle clipping against the frame in use.
  always_comb begin
    x0    = CLIP_W'(cmd_x);
    y0    = CLIP_W'(cmd_y);
    x_end = x0 + $signed(CLIP_W'(cmd_w));
    y_end = y0 + $signed(CLIP_W'(cmd_h));
    lim_x = $signed(CLIP_W'(geom.width));
    lim_y = $signed(CLIP_W'(geom.height));
    sx    = x0[CLIP_W-1] ? '0 : x0;
    sy    = y0[CLIP_W-1] ? '0 : y0;
    ex    = (x_end < lim_x) ? x_end : lim_x;
    ey    = (y_end < lim_y) ? y_end : lim_y;
    fill_empty = (sx >= ex) || (sy >= ey);
  end

  // One multiplier: row start of a fill, or the row offset of a pixel access.
  assign y_op    = (cmd_type == REQ_FILL && cmd_y[POS_W-1]) ? '0 : cmd_y;
  assign mul_out = y_op * $signed({1'b0, geom.width});

  // Linear index of the current pixel, clamped into the frame.
  always_comb begin
    x_op    = X_OP_W'(cmd_x) + $signed(X_OP_W'(glyph_cnt));
    lin_idx = IDX_W'(prod) + IDX_W'(x_op);
    last_s  = $signed(IDX_W'(geom.last));
    if (lin_idx[IDX_W-1]) begin
      pix_addr  = '0;
      pix_clamp = 1'b1;
    end else if (lin_idx > last_s) begin
      pix_addr  = geom.last;
      pix_clamp = 1'b1;
    end else begin
      pix_addr  = lin_idx[ADDR_W-1:0];
      pix_clamp = 1'b0;
    end
    pix_hit   = (cmd_type == REQ_SET) || (cmd_type == REQ_READ) ||
                ((cmd_type == REQ_GLYPH) && glyph_bits[GLYPH_WIDTH-1]);
    glyph_end = (glyph_cnt == GK_W'(GLYPH_WIDTH - 1));
  end

  always_comb begin
    ram_cmd.wdata = cmd_color;
    ram_cmd.raddr = pix_addr;
    ram_cmd.re    = (state == ST_PIXEL) && (cmd_type == REQ_READ);
    case (state)
      ST_CLEAR: begin
        ram_cmd.we    = 1'b1;
        ram_cmd.waddr = clr_addr;
      end
      ST_FILL: begin
        ram_cmd.we    = 1'b1;
        ram_cmd.waddr = row_base + ADDR_W'(x_cnt);
      end
      ST_PIXEL: begin
        ram_cmd.we    = pix_hit && (cmd_type != REQ_READ);
        ram_cmd.waddr = pix_addr;
      end
      default: begin
        ram_cmd.we    = 1'b0;
        ram_cmd.waddr = pix_addr;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_CALC;
      end
      ST_CALC: begin
        case (cmd_type)
          REQ_CLEAR: state_next = ST_CLEAR;
          REQ_FILL:  state_next = fill_empty ? ST_DONE : ST_FILL;
          REQ_GLYPH: state_next = ST_PIXEL;
          REQ_SET:   state_next = ST_PIXEL;
          REQ_READ:  state_next = ST_PIXEL;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        if (clr_addr == geom.last) state_next = ST_DONE;
      end
      ST_FILL: begin
        if (x_cnt == x_last && y_cnt == y_last) state_next = ST_DONE;
      end
      ST_PIXEL: begin
        if (cmd_type == REQ_READ) begin
          state_next = ST_RDWAIT;
        end else if (cmd_type != REQ_GLYPH || glyph_end) begin
          state_next = ST_DONE;
        end
      end
      ST_RDWAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (rsp_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd_type   <= req.req_type;
        cmd_x      <= req.pos_x;
        cmd_y      <= req.pos_y;
        cmd_w      <= req.rect_width;
        cmd_h      <= req.rect_height;
        cmd_color  <= req.color;
        glyph_bits <= req.row_bits;
      end
      ST_CALC: begin
        prod        <= mul_out;
        row_base    <= mul_out[ADDR_W-1:0];
        x_lo        <= sx[X_W-1:0];
        x_cnt       <= sx[X_W-1:0];
        y_cnt       <= sy[Y_W-1:0];
        x_last      <= X_W'(ex - 1);
        y_last      <= Y_W'(ey - 1);
        clr_addr    <= '0;
        glyph_cnt   <= '0;
        res_color   <= '0;
        res_empty   <= (cmd_type == REQ_FILL) && fill_empty;
        res_clamped <= 1'b0;
      end
      ST_CLEAR: begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      ST_FILL: begin
        if (x_cnt == x_last) begin
          x_cnt    <= x_lo;
          y_cnt    <= y_cnt + Y_W'(1);
          row_base <= row_base + ADDR_W'(geom.width);
        end else begin
          x_cnt <= x_cnt + X_W'(1);
        end
      end
      ST_PIXEL: begin
        res_clamped <= res_clamped | (pix_clamp & pix_hit);
        glyph_bits  <= glyph_bits << 1;
        glyph_cnt   <= glyph_cnt + GK_W'(1);
      end
      ST_RDWAIT: begin
        res_color <= ram_rdata;
      end
      default: ;
    endcase
  end

  // Result register: a finished word waits here while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.read_color    <= res_color;
      rsp.empty_rect    <= res_empty;
      rsp.index_clamped <= res_clamped;
    end
  end

endmodule

// File: hdl/frame_store_rect_and_glyph_draw_core.sv
`timescale 1ns / 1ps
// Drawing core over a 16-bit frame store: clear, rectangle fill, glyph row,
// set pixel and read pixel. Depends on fsd_pkg, the channel interfaces,
// fsd_cfg_regs, fsd_draw_seq, fsd_frame_ram and the assertion macro header.
//
// Usage. Requests come in on the req channel and every request returns
// exactly one word on the rsp channel. Frame width and height are APB
// registers at byte addresses 0 and 4; pready is always high and a write
// lands at the access cycle. Write them only while no request is in flight.
// A glyph row walks its twelve pixels in turn. Fills and clears put down one
// pixel per cycle through the single write port of the frame memory.
// After reset the registers hold 320 by 240 and the result channel is empty;
// the frame memory is not cleared, so a pixel must be drawn before it is
// read. A request is taken only while the core is idle; a finished word waits
// in the result register while the receiver stalls, and a request that
// finishes meanwhile holds the core in its final state until that word is taken.
`include "frame_store_rect_and_glyph_draw_core_macros.svh"

module frame_store_rect_and_glyph_draw_core import fsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  fsd_req_if.sink               req,
  fsd_rsp_if.source             rsp
);

  fsd_geom_t        geom;
  fsd_ram_cmd_t     ram_cmd;
  logic [PIX_W-1:0] ram_rdata;

  // Register file; geometry follows a register write in the next cycle.
  fsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  // The sequencer owns both memory ports. Because it runs one request at a
  // time and a read is issued only after all earlier writes have landed, the
  // read-after-write ordering of the memory needs no forwarding.
  fsd_draw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .geom      (geom),
    .ram_cmd   (ram_cmd),
    .ram_rdata (ram_rdata)
  );

  fsd_frame_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (FRAME_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_cmd.we),
    .waddr (ram_cmd.waddr),
    .wdata (ram_cmd.wdata),
    .re    (ram_cmd.re),
    .raddr (ram_cmd.raddr),
    .rdata (ram_rdata)
  );

  // Memory writes happen only while a request is being worked on.
  `FSD_ASSERT_IMPL(a_write_while_busy, clk, rst, ram_cmd.we, !req.ready, "write while idle")
  // A pixel read never shares a cycle with a write.
  `FSD_ASSERT_NEVER(a_no_rw_overlap, clk, rst, ram_cmd.we && ram_cmd.re, "read and write overlap")
  // An accepted request makes the core busy on the next cycle.
  `FSD_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready, "not busy")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the frame store drawing core: directed and random
// draw requests against a shadow frame. Needs fsd_pkg, fsd_channels.sv and the core.
module tb_top;
  import fsd_pkg::*;

  // Request codes above REQ_READ have no meaning; the core must answer them with
  // an all-zero word and leave the frame alone.
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_READ + REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;

  // The longest quiet stretch of a correct run is a clear of the largest frame
  // (512 x 256 pixels, one per cycle) followed by the longest receiver stall.
  // The watchdog limit lies above that.
  localparam int WATCHDOG_CYCLES = 400000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RESET_CYCLES    = 6;
  // Frames up to this many pixels are cheap enough to clear or to fill with
  // rectangles of any size during the random part.
  localparam int SMALL_AREA      = 4096;

  typedef struct {
    logic [REQ_W-1:0]        req_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RECT_W-1:0]       rect_width;
    logic [RECT_W-1:0]       rect_height;
    logic [PIX_W-1:0]        color;
    logic [GLYPH_WIDTH-1:0]  row_bits;
  } draw_req_t;

  typedef struct {
    logic [PIX_W-1:0] read_color;
    logic             empty_rect;
    logic             index_clamped;
  } draw_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fsd_req_if req_ch ();
  fsd_rsp_if rsp_ch ();

  frame_store_rect_and_glyph_draw_core u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // Shadow copy of the core: frame contents, which entries have been written,
  // and the two geometry registers as last written over APB.
  logic [PIX_W-1:0]    shadow_frame [FRAME_DEPTH];
  bit                  shadow_written [FRAME_DEPTH];
  logic [FW_REG_W-1:0] shadow_width_reg;
  logic [FH_REG_W-1:0] shadow_height_reg;

  // Result words predicted at acceptance and not yet returned, oldest first.
  draw_rsp_t due_responses[$];

  int fail_count   = 0;
  int stuck_cycles = 0;
  int sink_hold    = 0;
  // While set, neither side inserts gaps, so words move back to back.
  bit steady_flow  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The registers are saturated into 1..MAX when the core uses them, so a
  // written zero means one pixel and anything above the maximum means the max.
  function automatic int width_in_use();
    if (shadow_width_reg == '0) return 1;
    if (int'(shadow_width_reg) > MAX_WIDTH) return MAX_WIDTH;
    return int'(shadow_width_reg);
  endfunction

  function automatic int height_in_use();
    if (shadow_height_reg == '0) return 1;
    if (int'(shadow_height_reg) > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(shadow_height_reg);
  endfunction

  // Linear pixel index y*width+x, clamped into the frame in use. The flag is
  // only ever raised here, so a glyph accumulates it over all the pixels it draws.
  function automatic int clamped_index(int x, int y, inout bit clamped);
    int last_idx;
    int idx;
    last_idx = width_in_use() * height_in_use() - 1;
    idx = y * width_in_use() + x;
    if (idx < 0) begin
      idx = 0;
      clamped = 1'b1;
    end else if (idx > last_idx) begin
      idx = last_idx;
      clamped = 1'b1;
    end
    return idx;
  endfunction

  function automatic void paint(int idx, logic [PIX_W-1:0] color);
    shadow_frame[idx] = color;
    shadow_written[idx] = 1'b1;
  endfunction

  // Applies one accepted request to the shadow frame and returns the word the
  // core has to answer with.
  function automatic draw_rsp_t draw_on_shadow(draw_req_t r);
    draw_rsp_t res;
    bit        hit;
    int        w, h, px, py, rw, rh, x0, y0, x1, y1;
    res.read_color    = '0;
    res.empty_rect    = 1'b0;
    res.index_clamped = 1'b0;
    hit = 1'b0;
    w  = width_in_use();
    h  = height_in_use();
    px = int'(r.pos_x);
    py = int'(r.pos_y);
    rw = int'(r.rect_width);
    rh = int'(r.rect_height);
    case (r.req_type)
      REQ_CLEAR: begin
        for (int i = 0; i < w * h; i++) paint(i, r.color);
      end
      REQ_FILL: begin
        // Clip the half-open rectangle [px, px+rw) x [py, py+rh) to the frame.
        x0 = (px > 0) ? px : 0;
        y0 = (py > 0) ? py : 0;
        x1 = (px + rw < w) ? px + rw : w;
        y1 = (py + rh < h) ? py + rh : h;
        if (x0 >= x1 || y0 >= y1) begin
          res.empty_rect = 1'b1;
        end else begin
          for (int y = y0; y < y1; y++)
            for (int x = x0; x < x1; x++) paint(y * w + x, r.color);
        end
      end
      REQ_GLYPH: begin
        // Bit 11 is the leftmost pixel, at pos_x; bit 0 lands at pos_x+11.
        for (int i = 0; i < GLYPH_WIDTH; i++)
          if (r.row_bits[i]) paint(clamped_index(px + GLYPH_WIDTH - 1 - i, py, hit), r.color);
      end
      REQ_SET: begin
        paint(clamped_index(px, py, hit), r.color);
      end
      REQ_READ: begin
        res.read_color = shadow_frame[clamped_index(px, py, hit)];
      end
      default: begin
      end
    endcase
    res.index_clamped = hit;
    return res;
  endfunction

  function automatic draw_req_t make_req(logic [REQ_W-1:0] kind, int x, int y, int rw, int rh,
                                         int color, int bits);
    draw_req_t r;
    r.req_type    = kind;
    r.pos_x       = x[POS_W-1:0];
    r.pos_y       = y[POS_W-1:0];
    r.rect_width  = rw[RECT_W-1:0];
    r.rect_height = rh[RECT_W-1:0];
    r.color       = color[PIX_W-1:0];
    r.row_bits    = bits[GLYPH_WIDTH-1:0];
    return r;
  endfunction

  // Gap length for either side: mostly none, often a few cycles, rarely long.
  function automatic int pause_len();
    int roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A coordinate for an axis of the given span: mostly inside, some around the
  // far edge, some just below zero and some anywhere in the 11-bit range.
  function automatic logic signed [POS_W-1:0] pick_coord(int span);
    int roll;
    int v;
    roll = $urandom_range(0, 9);
    if (roll < 6) v = $urandom_range(0, span - 1);
    else if (roll < 8) v = span - 4 + int'($urandom_range(0, 6));
    else if (roll < 9) v = -int'($urandom_range(1, 12));
    else v = $urandom;
    return v[POS_W-1:0];
  endfunction

  function automatic draw_req_t random_request();
    draw_req_t r;
    int        w, h, roll;
    bit        hit;
    w    = width_in_use();
    h    = height_in_use();
    hit  = 1'b0;
    roll = $urandom_range(0, 99);
    // Fields a request does not use still get random values; the core must
    // ignore them.
    r.color       = PIX_W'($urandom);
    r.row_bits    = GLYPH_WIDTH'($urandom);
    r.rect_width  = RECT_W'($urandom);
    r.rect_height = RECT_W'($urandom);
    r.pos_x       = pick_coord(w);
    r.pos_y       = pick_coord(h);
    if (roll < 3) begin
      r.req_type = (w * h <= SMALL_AREA) ? REQ_CLEAR : REQ_SET;
    end else if (roll < 18) begin
      r.req_type = REQ_FILL;
      // Rectangles of any size only on small frames, so a fill never covers
      // more than SMALL_AREA pixels.
      if (w * h > SMALL_AREA || $urandom_range(0, 3) != 0) begin
        r.rect_width  = RECT_W'($urandom_range(0, 12));
        r.rect_height = RECT_W'($urandom_range(0, 12));
      end
    end else if (roll < 38) begin
      r.req_type = REQ_GLYPH;
      if (roll < 22) r.row_bits = '1;
      else if (roll < 24) r.row_bits = '0;
    end else if (roll < 63) begin
      r.req_type = REQ_SET;
    end else if (roll < 93) begin
      r.req_type = REQ_READ;
    end else begin
      r.req_type = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    end
    // Never read a pixel the core has not written; turn such a read into a set.
    if (r.req_type == REQ_READ &&
        !shadow_written[clamped_index(int'(r.pos_x), int'(r.pos_y), hit)])
      r.req_type = REQ_SET;
    return r;
  endfunction

  // Offers one request after a random gap and predicts its result at the edge
  // where the core takes it. valid stays high on return, so back-to-back words
  // need no extra edge.
  task automatic send_request(draw_req_t r);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.req_type;
    req_ch.pos_x       <= r.pos_x;
    req_ch.pos_y       <= r.pos_y;
    req_ch.rect_width  <= r.rect_width;
    req_ch.rect_height <= r.rect_height;
    req_ch.color       <= r.color;
    req_ch.row_bits    <= r.row_bits;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    due_responses.push_back(draw_on_shadow(r));
  endtask

  // Stops offering requests until every predicted word has come back. The
  // trailing edge keeps the lowering of valid apart from any later raise.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle; the register takes the value
  // at the access edge. The select then drops so that writes never overlap.
  task automatic write_reg(logic [REG_IDX_W-1:0] index, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (index == REG_FRAME_WIDTH) shadow_width_reg = value[FW_REG_W-1:0];
    else shadow_height_reg = value[FH_REG_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Moves to a new geometry once the core is idle. Unused upper bits of the
  // data word are random. If the new frame has pixels that were never written,
  // a clear follows so that later reads stay on written pixels.
  task automatic set_frame(int width_val, int height_val);
    logic [APB_DATA_W-1:0] word;
    bit                    all_written;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    word = $urandom;
    word[FW_REG_W-1:0] = width_val[FW_REG_W-1:0];
    write_reg(REG_FRAME_WIDTH, word);
    word = $urandom;
    word[FH_REG_W-1:0] = height_val[FH_REG_W-1:0];
    write_reg(REG_FRAME_HEIGHT, word);
    all_written = 1'b1;
    for (int i = 0; i < width_in_use() * height_in_use(); i++)
      if (!shadow_written[i]) all_written = 1'b0;
    if (!all_written) send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, $urandom, 0));
  endtask

  // Random requests in the current geometry. Now and then the flow turns
  // steady or turns gappy again, and now and then the sender waits for every
  // outstanding word before going on.
  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) steady_flow = !steady_flow;
      if ($urandom_range(0, 59) == 0) wait_for_results();
      send_request(random_request());
    end
  endtask

  // Directed requests in the 320 x 240 frame left by reset: the clear comes
  // first so every later read hits a written pixel.
  task automatic test_reset_geometry();
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 16'h1234, 0));
    send_request(make_req(REQ_READ, 5, 5, 0, 0, 0, 0));
    // Color extremes at the two corners of the frame.
    send_request(make_req(REQ_SET, 0, 0, 0, 0, 16'hFFFF, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SET, 319, 239, 0, 0, 16'h0000, 0));
    send_request(make_req(REQ_READ, 319, 239, 0, 0, 0, 0));
    // Most negative coordinates clamp to index zero, largest ones to the last.
    send_request(make_req(REQ_SET, -1024, -1024, 0, 0, 16'h5555, 0));
    send_request(make_req(REQ_READ, -1, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_SET, 1023, 1023, 0, 0, 16'h8001, 0));
    send_request(make_req(REQ_READ, -1024, 1023, 0, 0, 0, 0));
    // x past the row end wraps into the next row without clamping.
    send_request(make_req(REQ_SET, 320, 0, 0, 0, 16'h7FFE, 0));
    send_request(make_req(REQ_READ, 0, 1, 0, 0, 0, 0));
    wait_for_results();
    // Fills: inside, zero width, zero height, wholly outside on either side,
    // and clipped at both corners of the frame.
    send_request(make_req(REQ_FILL, 10, 10, 4, 3, 16'hBEEF, 0));
    send_request(make_req(REQ_READ, 13, 12, 0, 0, 0, 0));
    send_request(make_req(REQ_FILL, 5, 5, 0, 7, 16'h1111, 0));
    send_request(make_req(REQ_FILL, 5, 5, 7, 0, 16'h2222, 0));
    send_request(make_req(REQ_FILL, 400, 0, 10, 10, 16'h3333, 0));
    send_request(make_req(REQ_FILL, -20, -20, 10, 10, 16'h4444, 0));
    send_request(make_req(REQ_FILL, 310, 235, 1023, 1023, 16'hC0DE, 0));
    send_request(make_req(REQ_FILL, -5, -5, 10, 10, 16'h6666, 0));
    // Glyph rows: full, sparse over the first, and partly off either end.
    send_request(make_req(REQ_GLYPH, 100, 50, 0, 0, 16'h0F0F, 12'hFFF));
    send_request(make_req(REQ_GLYPH, 100, 50, 0, 0, 16'hF0F0, 12'h801));
    send_request(make_req(REQ_READ, 111, 50, 0, 0, 0, 0));
    send_request(make_req(REQ_GLYPH, 315, 239, 0, 0, 16'h3C3C, 12'hFFF));
    send_request(make_req(REQ_GLYPH, -5, 0, 0, 0, 16'h4242, 12'hA5A));
    // Unknown request codes.
    send_request(make_req(REQ_SPARE_FIRST, 1, 1, 1, 1, 16'hFFFF, 12'hFFF));
    send_request(make_req(REQ_SPARE_LAST, 1, 1, 1, 1, 16'hFFFF, 12'hFFF));
  endtask

  task automatic test_small_frames();
    for (int k = 0; k < 4; k++) begin
      set_frame($urandom_range(1, 40), $urandom_range(1, 24));
      run_random(70);
    end
  endtask

  // Register extremes: zero saturates to one pixel, all ones and anything past
  // the maximum saturate to the 512 x 256 frame, plus one-row and one-column
  // frames. The only full-size clear of the run happens here.
  task automatic test_frame_extremes();
    set_frame(0, 0);
    run_random(50);
    set_frame(1023, 511);
    run_random(70);
    set_frame(MAX_WIDTH, 1);
    run_random(30);
    set_frame(1, MAX_HEIGHT);
    run_random(30);
    set_frame($urandom_range(MAX_WIDTH + 1, 1023), $urandom_range(MAX_HEIGHT + 1, 511));
    run_random(30);
    set_frame(1, 1);
    run_random(20);
  endtask

  task automatic test_mid_frames();
    for (int k = 0; k < 2; k++) begin
      set_frame($urandom_range(17, MAX_WIDTH), $urandom_range(1, MAX_HEIGHT));
      run_random(80);
    end
  endtask

  // Receiver: ready drops for random stretches; no new stretch starts while the flow is steady.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      rsp_ch.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_hold <= pause_len();
    end
  end

  // Every returned word is compared with the oldest prediction.
  always @(posedge clk) begin
    draw_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_responses.size() == 0) begin
        $error("result word with no request outstanding");
        fail_count++;
      end else begin
        want = due_responses.pop_front();
        if (rsp_ch.read_color !== want.read_color) begin
          $error("read_color: expected %h, actual %h", want.read_color, rsp_ch.read_color);
          fail_count++;
        end
        if (rsp_ch.empty_rect !== want.empty_rect) begin
          $error("empty_rect: expected %b, actual %b", want.empty_rect, rsp_ch.empty_rect);
          fail_count++;
        end
        if (rsp_ch.index_clamped !== want.index_clamped) begin
          $error("index_clamped: expected %b, actual %b", want.index_clamped,
                 rsp_ch.index_clamped);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= WATCHDOG_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_CLEAR;
    req_ch.pos_x       <= '0;
    req_ch.pos_y       <= '0;
    req_ch.rect_width  <= '0;
    req_ch.rect_height <= '0;
    req_ch.color       <= '0;
    req_ch.row_bits    <= '0;
    shadow_width_reg  = FW_REG_W'(FRAME_WIDTH_RESET);
    shadow_height_reg = FH_REG_W'(FRAME_HEIGHT_RESET);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_small_frames();
    test_frame_extremes();
    test_mid_frames();

    // Let every outstanding word come back, then give the core a few more
    // cycles to show any word it should not send.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
